// ===== hw/rtl/dlpp_pkg.sv =====
//------------------------------------------------------------------------------
// dlpp_pkg
// Shared types and constants of the display list palette processor.
//------------------------------------------------------------------------------
`default_nettype none

package dlpp_pkg;

  localparam int unsigned PalEntries = 32;
  localparam int unsigned PalIdxW    = $clog2(PalEntries);

  // request kinds
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_WORD = 2'd1;
  localparam logic [1:0] REQ_PAL  = 2'd2;

  // result kinds
  localparam logic [1:0] RES_FETCH = 2'd0;
  localparam logic [1:0] RES_LINE  = 2'd1;
  localparam logic [1:0] RES_PAL   = 2'd2;

  // parse phases
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_H0   = 3'd1;
  localparam logic [2:0] PH_H1   = 3'd2;
  localparam logic [2:0] PH_H2   = 3'd3;
  localparam logic [2:0] PH_H3   = 3'd4;
  localparam logic [2:0] PH_CMD  = 3'd5;

  localparam logic [31:0] HEAD_RESET = 32'h000B_0000;
  localparam logic [8:0]  HOLD_END   = 9'd511;

  typedef logic [7:0] chan_t;

  function automatic logic [10:0] width_sel(input logic [2:0] s);
    logic [10:0] w;
    case (s)
      3'd1:    w = 11'd384;
      3'd2:    w = 11'd512;
      3'd3:    w = 11'd640;
      3'd4:    w = 11'd1024;
      default: w = 11'd320;
    endcase
    return w;
  endfunction

  function automatic chan_t ramp_val(input logic [PalIdxW-1:0] i);
    return {i, i[PalIdxW-1 -: 3]};
  endfunction

endpackage : dlpp_pkg

`default_nettype wire

// ===== hw/rtl/display_list_palette_processor_unit.sv =====
// Output: a result is registered in the output register, or in the skid register.
// Throughput: one input transaction per cycle while in_stall is low; the skid
//   register holds one result on out_stall; in_stall is high while it is full.
// Reset: synchronous active-low rst_n; palette returns to its ramp, all list
//   state clears, head address reloads 0xB0000. Config writes always ready.
//------------------------------------------------------------------------------
// display_list_palette_processor_unit
// Per-scanline display list parser, palette and line record generator.
//------------------------------------------------------------------------------
`default_nettype none

module display_list_palette_processor_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_head_addr,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [10:0] in_line_num,
  input  wire logic [31:0] in_word,
  input  wire logic [dlpp_pkg::PalIdxW-1:0] in_pal_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_result_kind,
  output logic [31:0]      out_fetch_addr,
  output logic [10:0]      out_line_y,
  output logic             out_visible,
  output logic [31:0]      out_prev_bitmap,
  output logic [31:0]      out_cur_bitmap,
  output logic [31:0]      out_out_control,
  output logic [31:0]      out_dma_control,
  output logic [23:0]      out_background,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue
);
  import dlpp_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] faddr;
    logic [10:0] y;
    logic        vis;
    logic [31:0] prevb;
    logic [31:0] curb;
    logic [31:0] ctrl;
    logic [31:0] dma;
    logic [23:0] bg;
    chan_t       r;
    chan_t       g;
    chan_t       b;
  } res_t;

  // ---------------- state ----------------
  logic [31:0] head_r;
  chan_t       pr_r [PalEntries];
  chan_t       pg_r [PalEntries];
  chan_t       pb_r [PalEntries];
  logic [23:0] bg_r, bg_nxt;
  logic [31:0] ctrl_r, ctrl_nxt, hdr_r, hdr_nxt;
  logic [31:0] cur_r, cur_nxt, prev_r, prev_nxt;
  logic [31:0] la_r, la_nxt, nla_r, nla_nxt;
  logic [8:0]  hold_r, hold_nxt;
  logic        stop_r, stop_nxt;
  logic [10:0] lw_r, lw_nxt;
  logic [2:0]  ph_r, ph_nxt;
  logic [5:0]  cl_r, cl_nxt;
  logic        skip_r, skip_nxt;
  logic [10:0] pend_r, pend_nxt;
  logic        sec_r, sec_nxt;

  // output register and skid register
  logic out_v_r, skid_v_r;
  res_t out_r, skid_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_v_r;
  wire   acc       = in_valid && !in_stall;

  // ---------------- single-pass logic ----------------
  logic        res_v;
  res_t        res;
  logic        pal_wr_r, pal_wr_g, pal_wr_b, pal_ramp;
  logic [PalIdxW-1:0] pen;
  logic        do_fetch, do_line, do_finish, fin_end;
  logic [10:0] line_sel;
  logic [8:0]  hold_f;
  logic [31:0] cur_a, prev_a;

  function automatic logic [31:0] adv(input logic [31:0] a, input logic [10:0] lw);
    return a[1] ? a + {19'd0, lw, 2'd0} - 32'd2 : a + 32'd2;
  endfunction

  always_comb begin
    bg_nxt = bg_r; ctrl_nxt = ctrl_r; hdr_nxt = hdr_r;
    cur_nxt = cur_r; prev_nxt = prev_r; la_nxt = la_r; nla_nxt = nla_r;
    hold_nxt = hold_r; stop_nxt = stop_r; lw_nxt = lw_r; ph_nxt = ph_r;
    cl_nxt = cl_r; skip_nxt = skip_r; pend_nxt = pend_r; sec_nxt = sec_r;
    pal_wr_r = 1'b0; pal_wr_g = 1'b0; pal_wr_b = 1'b0; pal_ramp = 1'b0;
    pen = in_word[24 +: PalIdxW];
    do_fetch = 1'b0; do_line = 1'b0; do_finish = 1'b0; fin_end = 1'b0;
    line_sel = in_line_num;
    res = '0; res_v = 1'b0;

    if (acc) begin
      case (in_req_type)
        REQ_TICK: begin
          if (ph_r == PH_IDLE) begin
            if (in_line_num == 11'd0) begin
              hold_nxt = 9'd0; stop_nxt = 1'b0; la_nxt = head_r;
              pend_nxt = 11'd0; sec_nxt = 1'b1; do_fetch = 1'b1;
            end else if (hold_r == 9'd0 && !stop_r) begin
              pend_nxt = in_line_num; sec_nxt = 1'b0; do_fetch = 1'b1;
            end else begin
              do_line = 1'b1;
            end
          end
        end
        REQ_WORD: begin
          case (ph_r)
            PH_H0: begin
              if (in_word == 32'd0) begin
                do_finish = 1'b1; fin_end = 1'b1;
              end else begin
                hdr_nxt = in_word; ph_nxt = PH_H1;
              end
            end
            PH_H1: begin
              if (hdr_r[16]) cur_nxt = in_word;
              ph_nxt = PH_H2;
            end
            PH_H2: begin
              if (hdr_r[15]) prev_nxt = in_word;
              ph_nxt = PH_H3;
            end
            PH_H3: begin
              nla_nxt = hdr_r[18] ? la_r + in_word + 32'd16 : in_word;
              cl_nxt = hdr_r[14:9];
              if (hdr_r[14:9] == 6'd0) do_finish = 1'b1;
              else ph_nxt = PH_CMD;
            end
            PH_CMD: begin
              if (!in_word[31]) begin
                case (in_word[30:29])
                  2'b00:   begin pal_wr_r = 1'b1; pal_wr_g = 1'b1; pal_wr_b = 1'b1; end
                  2'b11:   pal_wr_r = 1'b1;
                  2'b10:   pal_wr_g = 1'b1;
                  default: pal_wr_b = 1'b1;
                endcase
              end else if (in_word[31:24] == 8'hE0) begin
                if (!skip_r) bg_nxt = {in_word[7:0], in_word[15:8], in_word[23:16]};
              end else if (in_word[31:29] == 3'b110) begin
                if (!skip_r) begin
                  ctrl_nxt = in_word; skip_nxt = in_word[1];
                end
              end else if (in_word == 32'hFFFF_FFFF) begin
                if (!skip_r) pal_ramp = 1'b1;
              end
              cl_nxt = cl_r - 6'd1;
              if (cl_r == 6'd1) do_finish = 1'b1;
            end
            default: ;
          endcase
        end
        REQ_PAL: begin
          res_v = 1'b1;
          res.kind = RES_PAL;
          res.r = pr_r[in_pal_index];
          res.g = pg_r[in_pal_index];
          res.b = pb_r[in_pal_index];
        end
        default: ;
      endcase
    end

    // list completion: reload hold, then second fetch or pending record
    if (do_finish) begin
      ph_nxt = PH_IDLE;
      if (fin_end) begin
        hold_f = HOLD_END;
      end else begin
        la_nxt = nla_nxt;
        lw_nxt = width_sel(hdr_r[25:23]);
        hold_f = hdr_r[8:0];
      end
      hold_nxt = hold_f;
      stop_nxt = 1'b0;
      line_sel = pend_r;
      if (sec_r) begin
        sec_nxt = 1'b0;
        if (hold_f == 9'd0) do_fetch = 1'b1;
        else do_line = 1'b1;
      end else begin
        do_line = 1'b1;
      end
    end else begin
      hold_f = hold_r;
    end

    if (do_fetch) begin
      res_v = 1'b1; res.kind = RES_FETCH; res.faddr = la_nxt;
      ph_nxt = PH_H0; skip_nxt = 1'b0;
    end

    // line record uses state as updated by this transaction (cur/prev/ctrl/bg)
    cur_a = cur_nxt; prev_a = prev_nxt;
    if (do_line) begin
      res_v = 1'b1; res.kind = RES_LINE;
      res.y = line_sel;
      res.vis = (line_sel >= 11'd16) && (line_sel < 11'd256);
      res.prevb = prev_a; res.curb = cur_a;
      res.ctrl = ctrl_nxt; res.dma = hdr_nxt; res.bg = bg_nxt;
      cur_nxt = adv(cur_a, lw_nxt);
      prev_nxt = hdr_nxt[17] ? adv(prev_a, lw_nxt) : adv(cur_a, lw_nxt);
      if (!stop_nxt) begin
        if (hold_f == 9'd0) stop_nxt = 1'b1;
        else hold_nxt = hold_f - 9'd1;
      end
      ctrl_nxt = {ctrl_nxt[31:1], 1'b0};
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= HEAD_RESET;
      bg_r <= '0; ctrl_r <= '0; hdr_r <= '0; cur_r <= '0; prev_r <= '0;
      la_r <= '0; nla_r <= '0; hold_r <= '0; stop_r <= 1'b0; lw_r <= '0;
      ph_r <= PH_IDLE; cl_r <= '0; skip_r <= 1'b0; pend_r <= '0; sec_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) head_r <= cfg_head_addr;
      bg_r <= bg_nxt; ctrl_r <= ctrl_nxt; hdr_r <= hdr_nxt;
      cur_r <= cur_nxt; prev_r <= prev_nxt; la_r <= la_nxt; nla_r <= nla_nxt;
      hold_r <= hold_nxt; stop_r <= stop_nxt; lw_r <= lw_nxt; ph_r <= ph_nxt;
      cl_r <= cl_nxt; skip_r <= skip_nxt; pend_r <= pend_nxt; sec_r <= sec_nxt;
    end
  end

  // palette: 32 entries of flops, ramp restored at reset or by command
  always_ff @(posedge clk) begin
    for (int i = 0; i < PalEntries; i++) begin
      if (!rst_n || pal_ramp) begin
        pr_r[i] <= ramp_val(PalIdxW'(i));
        pg_r[i] <= ramp_val(PalIdxW'(i));
        pb_r[i] <= ramp_val(PalIdxW'(i));
      end else if (pen == PalIdxW'(i)) begin
        if (pal_wr_r) pr_r[i] <= in_word[23:16];
        if (pal_wr_g) pg_r[i] <= in_word[15:8];
        if (pal_wr_b) pb_r[i] <= in_word[7:0];
      end
    end
  end

  // output stage with skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0; skid_v_r <= 1'b0;
    end else begin
      if (!out_v_r || !out_stall) begin
        if (skid_v_r) begin
          out_v_r <= 1'b1; out_r <= skid_r; skid_v_r <= 1'b0;
        end else begin
          out_v_r <= res_v; out_r <= res;
        end
      end else if (res_v) begin
        skid_v_r <= 1'b1; skid_r <= res;
      end
    end
  end

  assign out_valid       = out_v_r;
  assign out_result_kind = out_r.kind;
  assign out_fetch_addr  = out_r.faddr;
  assign out_line_y      = out_r.y;
  assign out_visible     = out_r.vis;
  assign out_prev_bitmap = out_r.prevb;
  assign out_cur_bitmap  = out_r.curb;
  assign out_out_control = out_r.ctrl;
  assign out_dma_control = out_r.dma;
  assign out_background  = out_r.bg;
  assign out_red         = out_r.r;
  assign out_green       = out_r.g;
  assign out_blue        = out_r.b;

endmodule : display_list_palette_processor_unit

`default_nettype wire

// ===== test/tb_top.sv =====
//------------------------------------------------------------------------------
// tb_top
// Self-checking bench for the display list palette processor: line ticks,
// list words and palette reads are driven through a valid/stall channel and
// every result is compared with a built-in model of list parsing and palette.
//------------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dlpp_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] line;
    logic [31:0] word;
    logic [4:0]  idx;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] faddr;
    logic [10:0] y;
    logic        vis;
    logic [31:0] prevb;
    logic [31:0] curb;
    logic [31:0] ctrl;
    logic [31:0] dma;
    logic [23:0] bg;
    logic [7:0]  r, g, b;
  } rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_head_addr = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = '0;
  logic [10:0] in_line_num = '0;
  logic [31:0] in_word = '0;
  logic [4:0]  in_pal_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_result_kind;
  logic [31:0] out_fetch_addr;
  logic [10:0] out_line_y;
  logic        out_visible;
  logic [31:0] out_prev_bitmap, out_cur_bitmap, out_out_control, out_dma_control;
  logic [23:0] out_background;
  logic [7:0]  out_red, out_green, out_blue;
  rec_t        got;

  display_list_palette_processor_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_head_addr(cfg_head_addr),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_line_num(in_line_num), .in_word(in_word), .in_pal_index(in_pal_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_kind(out_result_kind), .out_fetch_addr(out_fetch_addr),
    .out_line_y(out_line_y), .out_visible(out_visible),
    .out_prev_bitmap(out_prev_bitmap), .out_cur_bitmap(out_cur_bitmap),
    .out_out_control(out_out_control), .out_dma_control(out_dma_control),
    .out_background(out_background), .out_red(out_red), .out_green(out_green),
    .out_blue(out_blue)
  );

  assign got = {out_result_kind, out_fetch_addr, out_line_y, out_visible,
                out_prev_bitmap, out_cur_bitmap, out_out_control, out_dma_control,
                out_background, out_red, out_green, out_blue};

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- model state
  logic [31:0] m_head;
  logic [7:0]  m_pr [32];
  logic [7:0]  m_pg [32];
  logic [7:0]  m_pb [32];
  logic [23:0] m_bg;
  logic [31:0] m_ctrl, m_hdr, m_cur, m_prev, m_list, m_next;
  logic [8:0]  m_hold;
  logic        m_stopped, m_skip, m_second;
  logic [10:0] m_width, m_pending;
  logic [2:0]  m_phase;
  logic [5:0]  m_cmds;

  rec_t expected_q[$];
  req_t pending_q[$];
  int   errors = 0;

  // idling controls
  int   send_idle_pct = 9;
  int   recv_idle_pct = 58;
  int   recv_hold = 0;        // long receiver hold-off request, in cycles
  int   idle_cnt = 0;

  function automatic logic [7:0] ramp_of(int i);
    logic [4:0] v;
    v = i[4:0];
    return {v, v[4:2]};
  endfunction

  task automatic model_ramp();
    for (int i = 0; i < 32; i++) begin
      m_pr[i] = ramp_of(i); m_pg[i] = ramp_of(i); m_pb[i] = ramp_of(i);
    end
  endtask

  task automatic model_reset();
    m_head = HEAD_RESET;
    model_ramp();
    m_bg = '0; m_ctrl = '0; m_hdr = '0; m_cur = '0; m_prev = '0;
    m_list = '0; m_next = '0; m_hold = '0; m_stopped = 1'b0; m_width = '0;
    m_phase = PH_IDLE; m_cmds = '0; m_skip = 1'b0; m_pending = '0; m_second = 1'b0;
  endtask

  function automatic logic [31:0] step_addr(logic [31:0] a);
    if (a[1]) return a + {19'd0, m_width, 2'd0} - 32'd2;
    return a + 32'd2;
  endfunction

  task automatic push_fetch();
    rec_t e;
    e = '0;
    e.kind = RES_FETCH;
    e.faddr = m_list;
    m_phase = PH_H0;
    m_skip = 1'b0;
    expected_q.push_back(e);
  endtask

  task automatic push_line(logic [10:0] ln);
    rec_t e;
    e = '0;
    e.kind = RES_LINE;
    e.y = ln;
    e.vis = (ln >= 11'd16 && ln < 11'd256);
    e.prevb = m_prev; e.curb = m_cur; e.ctrl = m_ctrl; e.dma = m_hdr; e.bg = m_bg;
    expected_q.push_back(e);
    m_cur = step_addr(m_cur);
    if (!m_hdr[17]) m_prev = m_cur;
    else m_prev = step_addr(m_prev);
    if (!m_stopped) begin
      if (m_hold == 9'd0) m_stopped = 1'b1;
      else m_hold = m_hold - 9'd1;
    end
    m_ctrl[0] = 1'b0;
  endtask

  task automatic close_list(bit ended);
    m_phase = PH_IDLE;
    if (ended) m_hold = HOLD_END;
    else begin
      m_list = m_next;
      case (m_hdr[25:23])
        3'd1: m_width = 11'd384;
        3'd2: m_width = 11'd512;
        3'd3: m_width = 11'd640;
        3'd4: m_width = 11'd1024;
        default: m_width = 11'd320;
      endcase
      m_hold = m_hdr[8:0];
    end
    m_stopped = 1'b0;
    if (m_second) begin
      m_second = 1'b0;
      if (m_hold == 9'd0) begin
        push_fetch();
        return;
      end
    end
    push_line(m_pending);
  endtask

  task automatic apply_cmd(logic [31:0] c);
    logic [4:0] pen;
    pen = c[28:24];
    if (!c[31]) begin
      case (c[30:29])
        2'b00: begin m_pr[pen] = c[23:16]; m_pg[pen] = c[15:8]; m_pb[pen] = c[7:0]; end
        2'b11: m_pr[pen] = c[23:16];
        2'b10: m_pg[pen] = c[15:8];
        default: m_pb[pen] = c[7:0];
      endcase
    end else if (c[31:24] == 8'hE0) begin
      if (!m_skip) m_bg = {c[7:0], c[15:8], c[23:16]};
    end else if (c[31:29] == 3'b110) begin
      if (!m_skip) begin m_ctrl = c; m_skip = c[1]; end
    end else if (c == 32'hFFFF_FFFF) begin
      if (!m_skip) model_ramp();
    end
  endtask

  // predicts the results of one accepted request
  task automatic predict_request(req_t q);
    rec_t e;
    case (q.kind)
      REQ_TICK: begin
        if (m_phase == PH_IDLE) begin
          if (q.line == 11'd0) begin
            m_hold = 9'd0; m_stopped = 1'b0; m_list = m_head; m_pending = 11'd0;
            m_second = 1'b1;
            push_fetch();
          end else if (m_hold == 9'd0 && !m_stopped) begin
            m_pending = q.line; m_second = 1'b0;
            push_fetch();
          end else push_line(q.line);
        end
      end
      REQ_WORD: begin
        case (m_phase)
          PH_H0: if (q.word == 32'd0) close_list(1'b1);
                 else begin m_hdr = q.word; m_phase = PH_H1; end
          PH_H1: begin if (m_hdr[16]) m_cur = q.word; m_phase = PH_H2; end
          PH_H2: begin if (m_hdr[15]) m_prev = q.word; m_phase = PH_H3; end
          PH_H3: begin
            m_next = m_hdr[18] ? m_list + q.word + 32'd16 : q.word;
            m_cmds = m_hdr[14:9];
            if (m_cmds == 6'd0) close_list(1'b0);
            else m_phase = PH_CMD;
          end
          PH_CMD: begin
            apply_cmd(q.word);
            m_cmds = m_cmds - 6'd1;
            if (m_cmds == 6'd0) close_list(1'b0);
          end
          default: ;
        endcase
      end
      REQ_PAL: begin
        e = '0;
        e.kind = RES_PAL;
        e.r = m_pr[q.idx]; e.g = m_pg[q.idx]; e.b = m_pb[q.idx];
        expected_q.push_back(e);
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req_t q;
          q = pending_q.pop_front();
          in_valid <= 1'b1;
          in_req_type <= q.kind; in_line_num <= q.line;
          in_word <= q.word; in_pal_index <= q.idx;
        end else in_valid <= 1'b0;
      end
    end
  end

  // model runs on the accepted transaction
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      predict_request('{in_req_type, in_line_num, in_word, in_pal_index});
  end

  // ---------------------------------------------------------------- receiver / monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (recv_hold > 0) begin
        recv_hold <= recv_hold - 1;
        out_stall <= 1'b1;
      end else out_stall <= ($urandom_range(99) < recv_idle_pct);
      if (out_valid && !out_stall) begin
        rec_t e;
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: kind %0d", got.kind);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (e.kind  !== got.kind)  begin $error("result_kind exp %h got %h", e.kind, got.kind); errors++; end
          if (e.faddr !== got.faddr) begin $error("fetch_addr exp %h got %h", e.faddr, got.faddr); errors++; end
          if (e.y     !== got.y)     begin $error("line_y exp %h got %h", e.y, got.y); errors++; end
          if (e.vis   !== got.vis)   begin $error("visible exp %h got %h", e.vis, got.vis); errors++; end
          if (e.prevb !== got.prevb) begin $error("prev_bitmap exp %h got %h", e.prevb, got.prevb); errors++; end
          if (e.curb  !== got.curb)  begin $error("cur_bitmap exp %h got %h", e.curb, got.curb); errors++; end
          if (e.ctrl  !== got.ctrl)  begin $error("out_control exp %h got %h", e.ctrl, got.ctrl); errors++; end
          if (e.dma   !== got.dma)   begin $error("dma_control exp %h got %h", e.dma, got.dma); errors++; end
          if (e.bg    !== got.bg)    begin $error("background exp %h got %h", e.bg, got.bg); errors++; end
          if (e.r     !== got.r)     begin $error("red exp %h got %h", e.r, got.r); errors++; end
          if (e.g     !== got.g)     begin $error("green exp %h got %h", e.g, got.g); errors++; end
          if (e.b     !== got.b)     begin $error("blue exp %h got %h", e.b, got.b); errors++; end
        end
      end
    end
  end

  // watchdog: cycles without any accepted input or output transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= 20000) begin
      $display("FAIL display_list_palette_processor_unit");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus helpers
  function automatic req_t mk(logic [1:0] k, logic [10:0] l, logic [31:0] w, logic [4:0] i);
    req_t q;
    q.kind = k; q.line = l; q.word = w; q.idx = i;
    return q;
  endfunction

  task automatic add_word(logic [31:0] w);
    pending_q.push_back(mk(REQ_WORD, 11'($urandom), w, 5'($urandom)));
  endtask

  function automatic logic [31:0] rand_cmd();
    case ($urandom_range(5))
      0: return {1'b0, 31'($urandom)};
      1: return {8'hE0, 24'($urandom)};
      2: return {3'b110, 29'($urandom)};
      3: return 32'hFFFF_FFFF;
      4: return {1'b1, 31'($urandom)};
      default: return {3'b110, 27'($urandom), 1'b0, 1'($urandom)};
    endcase
  endfunction

  // one well-formed list: header, three words, commands; or a zero end-of-list word
  task automatic add_list(int ncmd, bit end_list);
    logic [31:0] h;
    if (end_list) begin
      add_word(32'h0);
      return;
    end
    h = $urandom;
    h[14:9] = 6'(ncmd);
    if ($urandom_range(3) == 0) h[8:0] = 9'($urandom_range(3));
    else if ($urandom_range(1)) h[8:0] = 9'($urandom_range(20));
    if (h == 0) h = 32'h1;
    add_word(h);
    add_word($urandom); add_word($urandom); add_word($urandom);
    for (int i = 0; i < ncmd; i++) add_word(rand_cmd());
  endtask

  // a frame: line zero, two queued lists, then line ticks with optional lists and palette reads
  task automatic add_frame(int nlines);
    pending_q.push_back(mk(REQ_TICK, 11'd0, $urandom, 5'($urandom)));
    add_list($urandom_range(4), $urandom_range(9) == 0);
    add_list($urandom_range(4), $urandom_range(9) == 0);
    for (int l = 1; l <= nlines; l++) begin
      pending_q.push_back(mk(REQ_TICK, 11'(l * $urandom_range(1, 12)), $urandom,
                             5'($urandom)));
      if ($urandom_range(2) == 0) add_list($urandom_range(3), $urandom_range(7) == 0);
      if ($urandom_range(4) == 0)
        pending_q.push_back(mk(REQ_PAL, 11'($urandom), $urandom, 5'($urandom)));
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_valid) @(posedge clk);
    while (expected_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_head(logic [31:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1; cfg_head_addr <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    m_head = v;
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    model_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset palette, stray word, unused kind, default head frame
    pending_q.push_back(mk(REQ_PAL, 11'd0, 32'd0, 5'd0));
    pending_q.push_back(mk(REQ_PAL, 11'h7FF, 32'hFFFF_FFFF, 5'd31));
    add_word(32'hDEAD_BEEF);
    pending_q.push_back(mk(2'd3, 11'h7FF, 32'hFFFF_FFFF, 5'd31));
    pending_q.push_back(mk(REQ_TICK, 11'd5, 32'd0, 5'd0));   // fetch before any header
    add_word(32'h0);                                          // end of list: zero width line
    pending_q.push_back(mk(REQ_TICK, 11'd0, 32'd0, 5'd0));
    add_word(32'h0005_2600);                                  // header: 19 commands, hold 0
    pending_q.push_back(mk(REQ_TICK, 11'd3, 32'd0, 5'd0));   // tick while parsing
    add_word(32'h1234_5678); add_word(32'h8765_4321); add_word(32'h40);
    for (int i = 0; i < 19; i++) add_word(rand_cmd());
    add_word(32'h0);                                          // end of list
    pending_q.push_back(mk(REQ_TICK, 11'd15, 32'd0, 5'd0));
    pending_q.push_back(mk(REQ_TICK, 11'd16, 32'd0, 5'd0));
    pending_q.push_back(mk(REQ_TICK, 11'd255, 32'd0, 5'd0));
    pending_q.push_back(mk(REQ_TICK, 11'd256, 32'd0, 5'd0));
    pending_q.push_back(mk(REQ_PAL, 11'd0, 32'd0, 5'd7));
    wait_drained();

    write_head(32'h0);
    add_frame(20);
    wait_drained();
    write_head(32'hFFFF_FFFF);
    add_frame(20);

    // receiver holds off long while sender keeps offering
    recv_hold = 300;
    for (int f = 0; f < 4; f++) add_frame($urandom_range(4, 24));
    wait_drained();

    send_idle_pct = 58; recv_idle_pct = 9;
    write_head($urandom);
    for (int f = 0; f < 4; f++) add_frame($urandom_range(4, 24));
    for (int i = 0; i < 40; i++)
      pending_q.push_back(mk(2'($urandom), 11'($urandom), $urandom, 5'($urandom)));
    wait_drained();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_head(HEAD_RESET);
    for (int f = 0; f < 3; f++) add_frame($urandom_range(4, 24));
    wait_drained();
    repeat (10) @(posedge clk);

    if (errors == 0 && expected_q.size() == 0)
      $display("PASS display_list_palette_processor_unit");
    else
      $display("FAIL display_list_palette_processor_unit");
    $finish;
  end

endmodule

`default_nettype wire
